>>> sv/mkbw_pkg.sv
// Package for the modified Kaiser-Bessel window core.
// Holds the Q0.32 series coefficients and shared types; no dependencies.
package mkbw_pkg;

  localparam int unsigned COEF_COUNT = 12;
  localparam int unsigned WIDTH_BITS = 32;

  typedef logic [31:0] q32_t;

  // Round-to-nearest Q0.32 values of A01..A12.
  function automatic q32_t coef_q32(input logic [3:0] k);
    q32_t c;
    begin
      case (k)
        4'd1:    c = 32'd17889183;
        4'd2:    c = 32'd135178105;
        4'd3:    c = 32'd453983102;
        4'd4:    c = 32'd857621278;
        4'd5:    c = 32'd1036886886;
        4'd6:    c = 32'd870572058;
        4'd7:    c = 32'd537012613;
        4'd8:    c = 32'd253618165;
        4'd9:    c = 32'd94639226;
        4'd10:   c = 32'd28605334;
        4'd11:   c = 32'd7145580;
        4'd12:   c = 32'd1499860;
        default: c = 32'd0;
      endcase
      return c;
    end
  endfunction

  // Control that travels alongside the data through the pipeline.
  typedef struct packed {
    logic valid;
    logic in_win;
  } stage_ctl_t;

endpackage

>>> sv/mkbw_div_cell.sv
// One cell of the restoring divider chain: produces one quotient bit per cycle while en is high.
// Depends on mkbw_pkg.
module mkbw_div_cell
  import mkbw_pkg::*;
#(
  parameter int NUM_W = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  stage_ctl_t       ctl_in,
  input  logic [NUM_W-1:0] rem_in,
  input  logic [31:0]      quo_in,
  input  logic [31:0]      div_in,
  output stage_ctl_t       ctl_out,
  output logic [NUM_W-1:0] rem_out,
  output logic [31:0]      quo_out,
  output logic [31:0]      div_out
);

  logic [NUM_W:0] shifted;
  logic           take;

  assign shifted = {rem_in, 1'b0};
  assign take    = shifted >= {{(NUM_W-31){1'b0}}, div_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
      div_out <= div_in;
      quo_out <= {quo_in[30:0], take};
      rem_out <= take ? NUM_W'(shifted - {{(NUM_W-31){1'b0}}, div_in})
                      : NUM_W'(shifted);
    end
  end

endmodule

>>> sv/mkbw_horner_cell.sv
// One Horner cell: acc = round(acc*arg / 2^32) + coefficient, registered.
// Depends on mkbw_pkg.
module mkbw_horner_cell
  import mkbw_pkg::*;
#(
  parameter int K = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  stage_ctl_t ctl_in,
  input  q32_t       acc_in,
  input  q32_t       arg_in,
  output stage_ctl_t ctl_out,
  output q32_t       acc_out,
  output q32_t       arg_out
);

  logic [63:0] prod;
  logic [32:0] rnd;

  assign prod = acc_in * arg_in;
  assign rnd  = 33'((prod + 64'h8000_0000) >> 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
      arg_out <= arg_in;
      // Cell K adds coefficient A_K.
      acc_out <= 32'(rnd + {1'b0, coef_q32(4'(K))});
    end
  end

endmodule

>>> sv/modified_kaiser_bessel_window_core.sv
// Modified Kaiser-Bessel window core (alpha 3.5 pi).
// Depends on mkbw_pkg, mkbw_div_cell and mkbw_horner_cell.
//
// Usage: a signed offset enters on s_axis (tdata), one item per cycle while
// tready is high. The user must write the window width W on the cfg channel
// only while the block is idle; the block itself does not enforce this.
// Each offset yields one item on m_axis: window_value in Q0.16 and the
// inside_window flag in tuser. The cell chain is one stage for
// magnitude/compare, 32 divider cells (one quotient bit each), one squaring
// stage, SERIES_TERMS Horner cells (clamped to 1..12) and one rounding stage.
// Throughput is one item per cycle while m_axis is not stalled.
// The whole chain advances together; when m_axis stalls with a result
// waiting, the chain holds and s_axis tready drops until the result is taken.
// Reset clears all valid bits and returns W to 65536.
module modified_kaiser_bessel_window_core
  import mkbw_pkg::*;
#(
  parameter int SERIES_TERMS     = 12,
  parameter int OFFSET_WIDTH     = 32,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [OFFSET_WIDTH-1:0] sample_offset
  input  logic [((OFFSET_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [RESULT_FRAC_BITS-1:0] window_value
  output logic [((RESULT_FRAC_BITS+7)/8)*8-1:0] m_axis_tdata,
  // [0] inside_window
  output logic [0:0] m_axis_tuser
);

  localparam int NT    = (SERIES_TERMS < 1) ? 1 :
                         (SERIES_TERMS > 12) ? 12 : SERIES_TERMS;
  // Holds 2|x| and remainders; at least 34 bits so W fits beside the shift.
  localparam int NUM_W = (OFFSET_WIDTH + 2 > 34) ? OFFSET_WIDTH + 2 : 34;
  localparam int FB    = RESULT_FRAC_BITS;
  localparam int DW    = ((FB+7)/8)*8;

  logic [31:0] width_reg;
  logic        en;

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= 32'd65536;
    end else if (cfg_valid) begin
      width_reg <= cfg_data;
    end
  end

  // Stage 0: magnitude and window test.
  logic [OFFSET_WIDTH-1:0] x;
  logic [OFFSET_WIDTH:0]   mag;
  logic [NUM_W-1:0]        num;
  logic                    inside0;
  stage_ctl_t              ctl0;
  logic [NUM_W-1:0]        num0;
  logic [31:0]             div0;

  assign x   = s_axis_tdata[OFFSET_WIDTH-1:0];
  assign mag = x[OFFSET_WIDTH-1] ? (OFFSET_WIDTH+1)'(-{1'b1, x})
                                 : {1'b0, x};
  assign num = NUM_W'({mag, 1'b0});
  assign inside0 = (width_reg != 32'd0) && (num < {{(NUM_W-32){1'b0}}, width_reg});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else if (en) begin
      ctl0.valid  <= s_axis_tvalid;
      ctl0.in_win <= inside0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0        <= inside0 ? num : '0;
      div0        <= (width_reg == 32'd0) ? 32'd1 : width_reg;
    end
  end

  // Divider chain: r = floor(num*2^32 / W); num < W so remainder starts as num.
  stage_ctl_t        dctl [33];
  logic [NUM_W-1:0]  drem [33];
  logic [31:0]       dquo [33];
  logic [31:0]       ddiv [33];

  assign dctl[0] = ctl0;
  assign drem[0] = num0;
  assign dquo[0] = '0;
  assign ddiv[0] = div0;

  for (genvar i = 0; i < 32; i++) begin : g_div
    mkbw_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(dctl[i]), .rem_in(drem[i]), .quo_in(dquo[i]), .div_in(ddiv[i]),
      .ctl_out(dctl[i+1]), .rem_out(drem[i+1]), .quo_out(dquo[i+1]),
      .div_out(ddiv[i+1])
    );
  end

  // Square stage: arg = 2^32 - floor(r^2/2^32), saturated.
  logic [63:0] r2;
  logic [32:0] arg_w;
  stage_ctl_t  sctl;
  q32_t        sarg;

  assign r2    = dquo[32] * dquo[32];
  assign arg_w = 33'h1_0000_0000 - {1'b0, r2[63:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      sarg <= arg_w[32] ? 32'hFFFF_FFFF : arg_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sctl.valid <= 1'b0;
    end else if (en) begin
      sctl.valid  <= dctl[32].valid;
      sctl.in_win <= dctl[32].in_win;
    end
  end

  // Horner chain: cell j adds coefficient A(NT-j), so the last cell adds A01.
  stage_ctl_t hctl [NT+1];
  q32_t       hacc [NT+1];
  q32_t       harg [NT+1];

  assign hctl[0] = sctl;
  assign harg[0] = sarg;
  // Starting with acc = 0 at the first cell gives exactly c_n.
  assign hacc[0] = '0;

  for (genvar j = 0; j < NT + 1; j++) begin : g_horner
    if (j < NT) begin : g_h
      mkbw_horner_cell #(.K(NT - j)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .ctl_in(hctl[j]), .acc_in(hacc[j]), .arg_in(harg[j]),
        .ctl_out(hctl[j+1]), .acc_out(hacc[j+1]), .arg_out(harg[j+1])
      );
    end
  end

  // Final multiply and rounding to Q0.FB.
  logic [63:0] yprod;
  logic [32:0] y;
  logic [33:0] v;
  logic [FB-1:0] vout;

  assign yprod = hacc[NT] * harg[NT];
  assign y     = 33'((yprod + 64'h8000_0000) >> 32);

  always_comb begin
    if (FB >= 32) begin
      v = {1'b0, y};
    end else begin
      v = 34'(({1'b0, y} + (34'd1 << (31 - FB))) >> (32 - FB));
    end
    if (v > 34'((64'd1 << FB) - 64'd1)) begin
      vout = '1;
    end else begin
      vout = v[FB-1:0];
    end
  end

  logic [FB-1:0] out_val;
  logic          out_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= hctl[NT].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside <= hctl[NT].in_win;
      out_val    <= hctl[NT].in_win ? vout : '0;
    end
  end

  assign m_axis_tdata = DW'(out_val);
  assign m_axis_tuser = out_inside;

endmodule

>>> sv/mkbw_checker.sv
// Port-level checker for modified_kaiser_bessel_window_core, bound to the top.
// Depends on the top level's port list only.
module mkbw_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
    else $error("nonzero value outside window");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind modified_kaiser_bessel_window_core mkbw_port_checker u_mkbw_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

>>> verif/mkbw_checker.sv
// Checker for the modified Kaiser-Bessel window core: predicts each window
// weight from the accepted offsets and compares it with the output stream.
// Depends on mkbw_pkg for the shared Q0.32 type.
`timescale 1ns / 100ps
module mkbw_checker
  import mkbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count,
  output int          weights_pending
);

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic [15:0] weight;
    logic        in_win;
  } weight_t;

  // A01..A12 rounded to Q0.32.
  localparam logic [31:0] SERIES_COEF [1:12] = '{
    32'd17889183, 32'd135178105, 32'd453983102, 32'd857621278,
    32'd1036886886, 32'd870572058, 32'd537012613, 32'd253618165,
    32'd94639226, 32'd28605334, 32'd7145580, 32'd1499860
  };

  q32_t    width_reg;
  weight_t expected_weights[$];

  function automatic logic [95:0] q32_product(input logic [95:0] a, input logic [95:0] b);
    return (a * b + 96'h8000_0000) >> 32;
  endfunction

  function automatic weight_t predict_weight(input logic [31:0] offset, input q32_t width);
    logic [32:0] mag;
    logic [95:0] ratio, ratio_sq, arg, acc, y, rounded;
    weight_t     res;
    mag = offset[31] ? (33'h1_0000_0000 - {1'b0, offset}) : {1'b0, offset};
    res = '0;
    if (width == 0 || (mag << 1) >= {1'b0, width})
      return res;
    ratio = ({63'd0, mag} << 33) / width;
    ratio_sq = (ratio * ratio) >> 32;
    arg = ONE_Q32 - ratio_sq;
    if (arg > 96'hFFFF_FFFF)
      arg = 96'hFFFF_FFFF;
    acc = SERIES_COEF[12];
    for (int k = 11; k >= 1; k--)
      acc = q32_product(acc, arg) + SERIES_COEF[k];
    y = q32_product(acc, arg);
    rounded = (y + 96'h8000) >> 16;
    res.weight = (rounded > 96'hFFFF) ? 16'hFFFF : rounded[15:0];
    res.in_win = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    weight_t want;
    if (rst) begin
      width_reg <= 32'd65536;
      fail_count <= 0;
      weights_pending <= 0;
      expected_weights.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_weights.push_back(predict_weight(s_axis_tdata, width_reg));
      if (cfg_valid && cfg_ready)
        width_reg <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_weights.size() == 0) begin
          $display("%0t: unexpected item weight=%0d inside=%0d", $time,
                   m_axis_tdata, m_axis_tuser[0]);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_weights.pop_front();
          if (want.weight !== m_axis_tdata || want.in_win !== m_axis_tuser[0]) begin
            $display("%0t: mismatch expected weight=%0d inside=%0d, actual weight=%0d inside=%0d",
                     $time, want.weight, want.in_win, m_axis_tdata, m_axis_tuser[0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      weights_pending <= expected_weights.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for the modified Kaiser-Bessel window core: drives offsets
// and width writes, random stalls, and gives the verdict from mkbw_checker.
`timescale 1ns / 100ps
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  int          fail_count;
  int          weights_pending;
  int          quiet_cycles;
  bit          idling_on;
  bit          hold_off_req;

  modified_kaiser_bessel_window_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  mkbw_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .weights_pending(weights_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: ends the run when no item moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, and one long hold-off so the pipeline fills.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      m_axis_tready <= !(idling_on && $urandom_range(0, 99) < 17);
    end
  end

  task automatic send_offset(input logic [31:0] offset);
    if (idling_on && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= offset;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_width(input logic [31:0] width);
    s_axis_tvalid <= 1'b0;
    // This wait lets the checker count the item accepted just before.
    @(posedge clk);
    while (weights_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offset inside the window when possible, otherwise zero.
  function automatic logic [31:0] inside_offset(input logic [31:0] width);
    logic [31:0] lim;
    logic [31:0] mag;
    lim = (width == 0) ? 0 : (width - 1) >> 1;
    mag = (lim == 0) ? 0 : $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic run_phase(input logic [31:0] width, input int random_items);
    logic [31:0] half;
    logic [31:0] pick;
    half = width >> 1;
    idling_on = 1'b0;
    // Centre, extremes and both sides of the window edge.
    send_offset(32'd0);
    send_offset(32'd1);
    send_offset(32'hFFFF_FFFF);
    send_offset(32'h7FFF_FFFF);
    send_offset(32'h8000_0000);
    send_offset(half);
    send_offset(-half);
    send_offset(half - 1);
    send_offset(1 - half);
    send_offset(half + 1);
    send_offset(inside_offset(width));
    for (int i = 0; i < random_items; i++) begin
      if (i == 40)
        idling_on = 1'b1;
      if (i == 100 && width == 32'd1000)
        hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < 75)
        pick = inside_offset(width);
      else if ($urandom_range(0, 1))
        pick = $urandom;
      else
        pick = half + $urandom_range(0, 3) - 2;
      send_offset(pick);
    end
  endtask

  initial begin
    logic [31:0] widths[7];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idling_on = 1'b0;
    hold_off_req = 1'b0;
    widths = '{32'd1, 32'd2, 32'hFFFF_FFFF, 32'd1000, 32'd3, 32'h8000_0001, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_phase(32'd65536, 190);
    foreach (widths[i]) begin
      write_width(widths[i]);
      run_phase(widths[i], 190);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (weights_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && weights_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/mkbw_pkg.sv
sv/mkbw_div_cell.sv
sv/mkbw_horner_cell.sv
sv/modified_kaiser_bessel_window_core.sv
sv/mkbw_checker.sv
verif/mkbw_checker.sv
verif/tb.sv
